// ===== src/rcid_pkg.sv =====
// Package with the shared types and constants of the refcounted identifier allocator.
`default_nettype none

package rcid_pkg;

   // Fixed field widths of the request and response channels.
   localparam int OP_W     = 3;
   localparam int ID_W     = 8;
   localparam int STATUS_W = 3;

   // The free search looks at the in-use bitmap one group of this many bits at a time.
   localparam int GROUP_W  = 16;
   localparam int GBIT_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC    = 3'd0,
      OP_INC      = 3'd1,
      OP_DEC      = 3'd2,
      OP_QUERY    = 3'd3,
      OP_CONTAINS = 3'd4,
      OP_INIT     = 3'd5,
      OP_UNINIT   = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_UNINIT   = 3'd1,
      ST_INITED   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4,
      ST_SAT      = 3'd5
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Control strobes from the sequencer to the datapath.
   typedef struct packed {
      logic busy;
      logic exec;
   } ctrl_type;

endpackage : rcid_pkg

`default_nettype wire

// ===== src/rcid_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module rcid_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : rcid_ram

`default_nettype wire

// ===== src/rcid_free_enc.sv =====
// Shared priority encoder that finds the lowest clear bit of a vector.
`default_nettype none

module rcid_free_enc #(
   parameter int WIDTH = 16
) (
   input  wire logic [WIDTH-1:0]         used_vec,
   output logic                          found,
   output logic      [$clog2(WIDTH)-1:0] index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (!used_vec[i]) begin
            found = 1'b1;
            index = i[$clog2(WIDTH)-1:0];
         end
      end
   end

endmodule : rcid_free_enc

`default_nettype wire

// ===== src/refcounted_id_allocator.sv =====
// Top level of the refcounted identifier allocator: sequencer, bitmap and count datapath.
`default_nettype none

// Usage
// A request item (req_op, req_id_in) is taken at a rising edge where start is high and
// busy is low. Every item, including an undefined op, produces exactly one response
// item, shown on the rsp_ ports for a single cycle while rsp_valid is high. The
// receiver cannot hold responses off; it must capture them in that cycle.
// Timing: the accept edge issues the count memory read and the group-level free
// search. The next cycle (busy high) decodes the item, does the in-group free
// search with the same shared encoder, writes the count memory and updates the
// bitmap. The response follows in the cycle after that. No new item is taken
// while busy is high, because of the read-modify-write of the count memory and
// the two passes through the shared encoder.
// The lowest free identifier is found in two steps: a summary bit per group of 16
// identifiers marks full groups, then the first free bit of the chosen group.
// Reset clears the enable flag, the in-use bitmap, its summary and the live count
// at once; the count memory is not cleared, since a count is only read for a live
// identifier, which was written when it was allocated. No clearing pass is needed.
module refcounted_id_allocator #(
   parameter int NUM_IDS     = 256,
   parameter int COUNT_WIDTH = 16,
   parameter int INIT_REFS   = 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [rcid_pkg::OP_W-1:0]          req_op,
   input  wire logic [rcid_pkg::ID_W-1:0]          req_id_in,
   output logic                                    rsp_valid,
   output logic      [rcid_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [rcid_pkg::ID_W-1:0]          rsp_id_out,
   output logic      [COUNT_WIDTH-1:0]             rsp_ref_count,
   output logic                                    rsp_present,
   output logic      [$clog2(NUM_IDS+1)-1:0]       rsp_live_count
);

   import rcid_pkg::*;

   localparam int IDX_W  = $clog2(NUM_IDS);
   localparam int LIVE_W = $clog2(NUM_IDS + 1);
   localparam int NG     = (NUM_IDS + GROUP_W - 1) / GROUP_W;
   localparam int PAD_N  = NG * GROUP_W;
   localparam int GRP_W  = (NG > 1) ? $clog2(NG) : 1;
   localparam int ENC_W  = (NG > GROUP_W) ? NG : GROUP_W;
   localparam int ENC_IW = $clog2(ENC_W);
   localparam int FULL_W = GRP_W + GBIT_W;

   // The initial count is clamped to the largest count the field can hold.
   localparam logic [32:0] CNT_MAX_WIDE = (33'd1 << COUNT_WIDTH) - 33'd1;
   localparam logic [32:0] INIT_WIDE    = (33'(INIT_REFS) > CNT_MAX_WIDE) ?
                                          CNT_MAX_WIDE : 33'(INIT_REFS);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = CNT_MAX_WIDE[COUNT_WIDTH-1:0];
   localparam logic [COUNT_WIDTH-1:0] INIT_VAL = INIT_WIDE[COUNT_WIDTH-1:0];

   // Sequencer and item registers.
   state_type               state_ff, state_in;
   ctrl_type                ctrl;
   logic                    accept;
   logic [OP_W-1:0]         op_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic                    id_ok_ff;
   logic [GRP_W-1:0]        grp_ff;
   logic                    grp_free_ff;

   // Table state.
   logic                    enabled_ff, enabled_in;
   logic [NUM_IDS-1:0]      in_use_ff, in_use_in;
   logic [NG-1:0]           summary_ff, summary_in;
   logic [LIVE_W-1:0]       used_ff, used_in;

   // Response registers.
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic [COUNT_WIDTH-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_present_ff, rsp_present_in;

   // Request identifier widened for the range check and trimmed to the table index.
   logic [31:0]             req_id_wide;
   logic [IDX_W-1:0]        req_idx;
   logic                    req_id_ok;

   // Shared encoder and count memory.
   logic [ENC_W-1:0]        enc_vec;
   logic                    enc_found;
   logic [ENC_IW-1:0]       enc_idx;
   logic [PAD_N-1:0]        use_pad_ff, use_pad_in;
   logic [GROUP_W-1:0]      grp_bits;
   logic [FULL_W-1:0]       alloc_full;
   logic [IDX_W-1:0]        alloc_idx;
   logic [31:0]             alloc_wide;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [COUNT_WIDTH-1:0]  mem_wdata;
   logic [COUNT_WIDTH-1:0]  mem_rdata;
   logic [COUNT_WIDTH-1:0]  cnt_dec;
   logic                    hit;

   // ------------------------------------------------------------------
   // Sequencer: idle until an item arrives, then execute it and return to idle.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         S_IDLE: begin
            ctrl.busy = 1'b0;
            ctrl.exec = 1'b0;
         end
         S_EXEC: begin
            ctrl.busy = 1'b1;
            ctrl.exec = 1'b1;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign busy   = ctrl.busy;
   assign accept = start && !ctrl.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // Request capture.
   // ------------------------------------------------------------------
   assign req_id_wide = {{(32 - ID_W){1'b0}}, req_id_in};
   assign req_idx     = req_id_wide[IDX_W-1:0];
   assign req_id_ok   = req_id_wide < 32'(NUM_IDS);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         idx_ff      <= req_idx;
         id_ok_ff    <= req_id_ok;
         grp_ff      <= enc_idx[GRP_W-1:0];
         grp_free_ff <= enc_found;
      end
   end

   // ------------------------------------------------------------------
   // Free search. Bits past the last identifier read as in use so they are
   // never handed out. While idle the encoder scans the group summary; in the
   // execute cycle it scans the chosen group.
   // ------------------------------------------------------------------
   assign use_pad_ff = {{(PAD_N - NUM_IDS){1'b1}}, in_use_ff};
   assign use_pad_in = {{(PAD_N - NUM_IDS){1'b1}}, in_use_in};
   assign grp_bits   = use_pad_ff[grp_ff * GROUP_W +: GROUP_W];

   always_comb begin
      enc_vec = '1;
      if (ctrl.exec) begin
         enc_vec[GROUP_W-1:0] = grp_bits;
      end else begin
         enc_vec[NG-1:0] = summary_ff;
      end
   end

   rcid_free_enc #(
      .WIDTH(ENC_W)
   ) u_free_enc (
      .used_vec(enc_vec),
      .found   (enc_found),
      .index   (enc_idx)
   );

   assign alloc_full = {grp_ff, enc_idx[GBIT_W-1:0]};
   assign alloc_idx  = alloc_full[IDX_W-1:0];
   assign alloc_wide = {{(32 - IDX_W){1'b0}}, alloc_idx};

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         summary_in[g] = &use_pad_in[g * GROUP_W +: GROUP_W];
      end
   end

   // ------------------------------------------------------------------
   // Count memory: read on the accept edge, written in the execute cycle.
   // The decode below runs on the held item in every cycle, so its write
   // strobe only reaches the memory in the execute cycle.
   // ------------------------------------------------------------------
   rcid_ram #(
      .WIDTH(COUNT_WIDTH),
      .DEPTH(NUM_IDS)
   ) u_count_ram (
      .clock  (clock),
      .wr_en  (mem_we && ctrl.exec),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(req_idx),
      .rd_data(mem_rdata)
   );

   // ------------------------------------------------------------------
   // Execute: decode the item and work out the new table state and response.
   // ------------------------------------------------------------------
   assign hit     = id_ok_ff && in_use_ff[idx_ff];
   assign cnt_dec = mem_rdata - COUNT_WIDTH'(1);

   always_comb begin
      enabled_in     = enabled_ff;
      in_use_in      = in_use_ff;
      used_in        = used_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = mem_rdata;
      rsp_status_in  = ST_OK;
      rsp_id_in      = '0;
      rsp_cnt_in     = '0;
      rsp_present_in = 1'b0;

      case (op_ff)
         OP_INIT: begin
            if (enabled_ff) begin
               rsp_status_in = ST_INITED;
            end else begin
               enabled_in = 1'b1;
               in_use_in  = '0;
               used_in    = '0;
            end
         end
         OP_UNINIT: begin
            if (!enabled_ff) begin
               rsp_status_in = ST_UNINIT;
            end else begin
               enabled_in = 1'b0;
               in_use_in  = '0;
               used_in    = '0;
            end
         end
         OP_ALLOC: begin
            if (!enabled_ff) begin
               rsp_status_in = ST_UNINIT;
            end else if (grp_free_ff && enc_found) begin
               in_use_in[alloc_idx] = 1'b1;
               used_in              = used_ff + LIVE_W'(1);
               mem_we               = 1'b1;
               mem_waddr            = alloc_idx;
               mem_wdata            = INIT_VAL;
               rsp_id_in            = alloc_wide[ID_W-1:0];
               rsp_cnt_in           = INIT_VAL;
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         OP_CONTAINS: begin
            if (!enabled_ff) begin
               rsp_status_in = ST_UNINIT;
            end else begin
               rsp_present_in = hit;
            end
         end
         OP_INC, OP_DEC, OP_QUERY: begin
            if (!enabled_ff) begin
               rsp_status_in = ST_UNINIT;
            end else if (!hit) begin
               rsp_status_in = ST_NOTFOUND;
            end else if (op_ff == OP_INC) begin
               if (mem_rdata == CNT_MAX) begin
                  rsp_status_in = ST_SAT;
                  rsp_cnt_in    = mem_rdata;
               end else begin
                  mem_we     = 1'b1;
                  mem_wdata  = mem_rdata + COUNT_WIDTH'(1);
                  rsp_cnt_in = mem_rdata + COUNT_WIDTH'(1);
               end
            end else if (op_ff == OP_DEC) begin
               mem_we     = 1'b1;
               mem_wdata  = cnt_dec;
               rsp_cnt_in = cnt_dec;
               // Dropping below the initial count releases the identifier.
               if (cnt_dec < INIT_VAL) begin
                  in_use_in[idx_ff] = 1'b0;
                  used_in           = used_ff - LIVE_W'(1);
               end
            end else begin
               rsp_cnt_in = mem_rdata;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         in_use_ff    <= '0;
         summary_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.exec;
         if (ctrl.exec) begin
            enabled_ff <= enabled_in;
            in_use_ff  <= in_use_in;
            summary_ff <= summary_in;
            used_ff    <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_id_ff      <= rsp_id_in;
         rsp_cnt_ff     <= rsp_cnt_in;
         rsp_present_ff <= rsp_present_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_id_out     = rsp_id_ff;
   assign rsp_ref_count  = rsp_cnt_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_live_count = used_ff;

endmodule : refcounted_id_allocator

`default_nettype wire

// ===== tb/rcid_checker.sv =====
// Checker that predicts every response item of the refcounted identifier allocator and compares it.
`timescale 1ns / 100ps

module rcid_checker #(
   parameter int NUM_IDS     = 256,
   parameter int COUNT_WIDTH = 16,
   parameter int INIT_REFS   = 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           busy,
   input  wire logic [rcid_pkg::OP_W-1:0]      req_op,
   input  wire logic [rcid_pkg::ID_W-1:0]      req_id_in,
   input  wire logic                           rsp_valid,
   input  wire logic [rcid_pkg::STATUS_W-1:0]  rsp_status,
   input  wire logic [rcid_pkg::ID_W-1:0]      rsp_id_out,
   input  wire logic [COUNT_WIDTH-1:0]         rsp_ref_count,
   input  wire logic                           rsp_present,
   input  wire logic [$clog2(NUM_IDS+1)-1:0]   rsp_live_count,
   output int                                  error_count,
   output int                                  pending_items
);
   import rcid_pkg::*;

   localparam int LIVE_W = $clog2(NUM_IDS+1);
   localparam longint MAX_WIDE = (64'd1 << COUNT_WIDTH) - 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] INIT_COUNT =
      (longint'(INIT_REFS) > MAX_WIDE) ? COUNT_MAX : COUNT_WIDTH'(INIT_REFS);

   typedef struct packed {
      status_type             status;
      logic [ID_W-1:0]        id_out;
      logic [COUNT_WIDTH-1:0] ref_count;
      logic                   present;
      logic [LIVE_W-1:0]      live_count;
   } response_type;

   // Shadow of the allocator table.
   bit                     enabled;
   bit                     live [NUM_IDS];
   logic [COUNT_WIDTH-1:0] counts [NUM_IDS];
   int                     live_total;

   response_type pending_responses [$];
   int           mismatches;
   int           response_index;

   function automatic void clear_table();
      for (int i = 0; i < NUM_IDS; i++) begin
         live[i] = 1'b0;
      end
      live_total = 0;
   endfunction

   function automatic response_type allocator_response(logic [OP_W-1:0] op,
                                                       logic [ID_W-1:0] id);
      response_type r;
      bit           known;
      int           slot;
      r        = '0;
      r.status = ST_OK;
      known    = (int'(id) < NUM_IDS) && live[id];
      if (op == OP_INIT) begin
         if (enabled) begin
            r.status = ST_INITED;
         end else begin
            clear_table();
            enabled = 1'b1;
         end
      end else if (op > OP_UNINIT) begin
         // Codes past the last defined op are ignored.
      end else if (!enabled) begin
         r.status = ST_UNINIT;
      end else begin
         case (op)
            OP_UNINIT: begin
               clear_table();
               enabled = 1'b0;
            end
            OP_ALLOC: begin
               slot = -1;
               for (int i = NUM_IDS - 1; i >= 0; i--) begin
                  if (!live[i]) slot = i;
               end
               if (slot < 0) begin
                  r.status = ST_FULL;
               end else begin
                  live[slot]   = 1'b1;
                  counts[slot] = INIT_COUNT;
                  live_total++;
                  r.id_out     = ID_W'(slot);
                  r.ref_count  = INIT_COUNT;
               end
            end
            OP_CONTAINS: r.present = known;
            default: begin
               if (!known) begin
                  r.status = ST_NOTFOUND;
               end else begin
                  case (op)
                     OP_INC: begin
                        if (counts[id] == COUNT_MAX) begin
                           r.status = ST_SAT;
                        end else begin
                           counts[id] = counts[id] + COUNT_WIDTH'(1);
                        end
                     end
                     OP_DEC: begin
                        counts[id] = counts[id] - COUNT_WIDTH'(1);
                        if (counts[id] < INIT_COUNT) begin
                           live[id] = 1'b0;
                           live_total--;
                        end
                     end
                     default: ;
                  endcase
                  r.ref_count = counts[id];
               end
            end
         endcase
      end
      r.live_count = LIVE_W'(live_total);
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_response(response_type e);
      if (rsp_status !== e.status)
         report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                   response_index, rsp_status, e.status));
      if (rsp_id_out !== e.id_out)
         report_mismatch($sformatf("response %0d id_out %0d, expected %0d",
                                   response_index, rsp_id_out, e.id_out));
      if (rsp_ref_count !== e.ref_count)
         report_mismatch($sformatf("response %0d ref_count %0d, expected %0d",
                                   response_index, rsp_ref_count, e.ref_count));
      if (rsp_present !== e.present)
         report_mismatch($sformatf("response %0d present %0b, expected %0b",
                                   response_index, rsp_present, e.present));
      if (rsp_live_count !== e.live_count)
         report_mismatch($sformatf("response %0d live_count %0d, expected %0d",
                                   response_index, rsp_live_count, e.live_count));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         enabled = 1'b0;
         pending_responses.delete();
      end else begin
         // A response at this edge always belongs to an earlier item.
         if (rsp_valid === 1'b1) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response item with no request outstanding");
            end else begin
               check_response(pending_responses.pop_front());
            end
            response_index++;
         end
         if (start && !busy) begin
            pending_responses.push_back(allocator_response(req_op, req_id_in));
         end
      end
      pending_items <= pending_responses.size();
      error_count   <= mismatches;
   end

endmodule

// ===== tb/refcounted_id_allocator_tb.sv =====
// Testbench top for the refcounted identifier allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module refcounted_id_allocator_tb;
   import rcid_pkg::*;

   localparam int NUM_IDS     = 256;
   localparam int COUNT_WIDTH = 16;
   localparam int INIT_REFS   = 1;
   localparam int LIVE_W      = $clog2(NUM_IDS+1);

   // The op field has one code with no meaning; the block must still answer it.
   localparam logic [OP_W-1:0] OP_UNUSED = '1;

   // The limit sits well above what about two thousand items and the random idle
   // bursts between them need, which leaves a wide margin.
   localparam int CYCLE_LIMIT = 200_000;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [OP_W-1:0]         req_op;
   logic [ID_W-1:0]         req_id_in;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [ID_W-1:0]         rsp_id_out;
   logic [COUNT_WIDTH-1:0]  rsp_ref_count;
   logic                    rsp_present;
   logic [LIVE_W-1:0]       rsp_live_count;

   int error_count;
   int pending_items;
   int cycles = 0;

   // When set, the sender inserts random idle bursts between items.
   bit idle_on;

   refcounted_id_allocator #(
      .NUM_IDS     (NUM_IDS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .INIT_REFS   (INIT_REFS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_id_in      (req_id_in),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_id_out     (rsp_id_out),
      .rsp_ref_count  (rsp_ref_count),
      .rsp_present    (rsp_present),
      .rsp_live_count (rsp_live_count)
   );

   // The checker sits beside the block, watches both channels, and predicts and
   // compares every response item on its own.
   rcid_checker #(
      .NUM_IDS     (NUM_IDS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .INIT_REFS   (INIT_REFS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_id_in      (req_id_in),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_id_out     (rsp_id_out),
      .rsp_ref_count  (rsp_ref_count),
      .rsp_present    (rsp_present),
      .rsp_live_count (rsp_live_count),
      .error_count    (error_count),
      .pending_items  (pending_items)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL refcounted_id_allocator");
         $finish;
      end
   end

   // Drops start for a random idle burst. The request fields carry junk meanwhile,
   // which the block must ignore since start is low.
   task automatic pause_sender();
      start     <= 1'b0;
      req_op    <= OP_W'($urandom);
      req_id_in <= ID_W'($urandom);
      repeat ($urandom_range(1, 15)) @(posedge clock);
   endtask

   // Presents one item and returns at the edge that accepts it. Start stays high
   // on return, so back-to-back items never lower and raise it in the same step.
   // Busy is read right after the edge, which gives its value before that edge.
   task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
      if (idle_on && $urandom_range(0, 7) == 0) pause_sender();
      req_op    <= op;
      req_id_in <= id;
      start     <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Directed checks: every op on a block that is switched off, double
   // initialization, unknown identifiers, reuse of the lowest freed identifier,
   // a full table, and a count raised well above its initial value.
   task automatic run_directed();
      send_item(OP_ALLOC, 8'd0);
      send_item(OP_INC, 8'd0);
      send_item(OP_DEC, 8'd0);
      send_item(OP_QUERY, 8'd0);
      send_item(OP_CONTAINS, 8'd0);
      send_item(OP_UNINIT, 8'd0);
      send_item(OP_UNUSED, 8'hFF);
      send_item(OP_INIT, 8'd0);
      send_item(OP_INIT, 8'd0);
      send_item(OP_ALLOC, 8'd0);
      send_item(OP_ALLOC, 8'd0);
      send_item(OP_INC, 8'd0);
      send_item(OP_QUERY, 8'd0);
      send_item(OP_CONTAINS, 8'd0);
      send_item(OP_CONTAINS, 8'hFF);
      // Dropping below the initial count frees identifier 1.
      send_item(OP_DEC, 8'd1);
      send_item(OP_QUERY, 8'd1);
      send_item(OP_INC, 8'hFF);
      send_item(OP_DEC, 8'd200);
      send_item(OP_ALLOC, 8'd0);
      send_item(OP_UNUSED, 8'd0);

      // Fill the table, overflow it, then free two holes and refill them in
      // ascending order.
      repeat (NUM_IDS) send_item(OP_ALLOC, ID_W'($urandom));
      send_item(OP_CONTAINS, 8'hFF);
      send_item(OP_DEC, 8'd128);
      send_item(OP_DEC, 8'd77);
      send_item(OP_ALLOC, 8'd0);
      send_item(OP_ALLOC, 8'd0);
      send_item(OP_ALLOC, 8'd0);
      send_item(OP_INC, 8'hFF);
      send_item(OP_DEC, 8'hFF);

      // Raise identifier 0 well above its initial count and walk it back by one.
      repeat (40) send_item(OP_INC, 8'd0);
      send_item(OP_DEC, 8'd0);
      send_item(OP_INC, 8'd0);
      send_item(OP_INC, 8'd0);
      send_item(OP_QUERY, 8'd0);

      send_item(OP_UNINIT, 8'd0);
      send_item(OP_UNINIT, 8'd0);
      send_item(OP_QUERY, 8'd0);
      send_item(OP_INIT, 8'd0);
   endtask

   // One random phase. The weights steer the live count up or down; id_hi bounds the
   // id range, which some phases keep near the low end where identifiers are live, since
   // allocation always takes the lowest free one, with a share of fully random identifiers.
   task automatic run_phase(int n_items, int alloc_w, int dec_w, int id_hi, bit idle);
      int               pick;
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  id;
      idle_on = idle;
      send_item(OP_INIT, ID_W'($urandom));
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < alloc_w) begin
            op = OP_ALLOC;
         end else if (pick < alloc_w + dec_w) begin
            op = OP_DEC;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      op = OP_INC;
            else if (pick < 70) op = OP_QUERY;
            else if (pick < 95) op = OP_CONTAINS;
            else if (pick < 97) op = OP_INIT;
            else if (pick < 99) op = OP_UNINIT;
            else                op = OP_UNUSED;
         end
         if ($urandom_range(0, 9) == 0) id = ID_W'($urandom);
         else                           id = ID_W'($urandom_range(0, id_hi));
         send_item(op, id);
         // A switch-off is usually followed at once by a switch-on, so most of
         // the traffic lands on an enabled block.
         if (op == OP_UNINIT && $urandom_range(0, 4) != 0) begin
            send_item(OP_INIT, ID_W'($urandom));
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_op    = OP_ALLOC;
      req_id_in = '0;
      idle_on   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      run_directed();

      // Random part: a mixed start, a fill that runs into a full table, a drain,
      // more mixed traffic, and a last stretch with no idling at all.
      run_phase(200, 40, 20, 15, $urandom_range(0, 3) != 0);
      run_phase(250, 80, 5, 255, $urandom_range(0, 3) != 0);
      run_phase(200, 10, 60, 255, $urandom_range(0, 3) != 0);
      run_phase(250, 35, 30, 63, $urandom_range(0, 3) != 0);
      run_phase(300, 60, 20, 255, $urandom_range(0, 3) != 0);
      run_phase(150, 30, 30, 31, $urandom_range(0, 3) != 0);
      run_phase(250, 35, 35, 255, 1'b0);
      start <= 1'b0;

      // The checker's outstanding count is registered and lags the queue, so wait for an edge first.
      @(posedge clock);
      while (pending_items != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && pending_items == 0) begin
         $display("PASS refcounted_id_allocator");
      end else begin
         $display("FAIL refcounted_id_allocator");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/rcid_pkg.sv
src/rcid_ram.sv
src/rcid_free_enc.sv
src/refcounted_id_allocator.sv
tb/rcid_checker.sv
tb/refcounted_id_allocator_tb.sv
